@@ hdl/tzpc_pkg.sv @@
package tzpc_pkg;

  localparam int SENSOR_COUNT = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TENSION_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULL_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_GAIN_Q8    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_SELECT_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_SELECT_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TENSION_BAND    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_LENGTH  = 3'd6;

  localparam logic [11:0] RST_TENSION_OFFSET  = 12'd10;
  localparam logic [7:0]  RST_PULL_GAIN       = 8'd10;
  localparam logic [15:0] RST_HOLD_GAIN_Q8    = 16'd2560;
  localparam logic [1:0]  RST_SENSOR_SELECT_A = 2'd0;
  localparam logic [1:0]  RST_SENSOR_SELECT_B = 2'd1;
  localparam logic [11:0] RST_TENSION_BAND    = 12'd30;
  localparam logic [6:0]  RST_AVERAGE_LENGTH  = 7'd5;

  localparam int LEN_W     = 7;
  localparam int MAX_AVG   = 64;
  localparam int SUM_W     = 22;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = LEN_W;
  localparam int BASE_W    = 18;
  localparam int DEV_W     = 20;
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int FRAC_W    = 8;

  localparam logic [1:0] ZONE_PULL    = 2'd0;
  localparam logic [1:0] ZONE_RELEASE = 2'd1;
  localparam logic [1:0] ZONE_HOLD    = 2'd2;

  typedef enum logic [1:0] {
    OP_POSITION = 2'd0,
    OP_TENSION  = 2'd1,
    OP_TICK     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_BASE,
    ST_PREP,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] position_1;
    logic signed [31:0] position_2;
    logic signed [15:0] tension_0;
    logic signed [15:0] tension_1;
    logic signed [15:0] tension_2;
    logic signed [15:0] tension_3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] command_1;
    logic signed [31:0] command_2;
    logic [1:0]         zone_1;
    logic [1:0]         zone_2;
  } out_item_t;

  typedef struct packed {
    logic [11:0] tension_offset;
    logic [7:0]  pull_gain;
    logic [15:0] hold_gain_q8;
    logic [1:0]  sensor_select_a;
    logic [1:0]  sensor_select_b;
    logic [11:0] tension_band;
    logic [6:0]  average_length;
  } cfg_t;

  typedef struct packed {
    logic load_pos;
    logic capture_ref;
    logic load_ten;
    logic accum;
    logic div_load;
    logic div_step;
    logic base_write;
    logic motor;
    logic prep;
    logic mul;
    logic acc;
    logic load_out;
  } cmd_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (int'(len) > MAX_AVG) begin
      res = LEN_W'(MAX_AVG);
    end
    return res;
  endfunction

  function automatic logic signed [15:0] pick_sensor(input in_item_t item,
                                                     input logic [1:0] sel);
    logic [1:0]         idx;
    logic signed [15:0] res;
    idx = sel;
    if (int'(sel) >= SENSOR_COUNT) begin
      idx = sel - 2'(SENSOR_COUNT);
    end
    case (idx)
      2'd0:    res = item.tension_0;
      2'd1:    res = item.tension_1;
      2'd2:    res = item.tension_2;
      2'd3:    res = item.tension_3;
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [31:0]      res;
    hi = ACC_W'(32'sh7FFF_FFFF);
    lo = ACC_W'(32'sh8000_0000);
    res = v[31:0];
    if (v > hi) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      res = 32'sh8000_0000;
    end
    return res;
  endfunction

endpackage

@@ hdl/tzpc_ctrl.sv @@
module tzpc_ctrl
  import tzpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       operation,
  input  logic             out_stall,
  input  logic [LEN_W-1:0] average_length,
  input  logic             div_done,
  output logic             in_stall,
  output logic             out_valid,
  output cmd_t             cmd
);

  state_t           state_r, state_nxt;
  logic             captured_r, captured_nxt;
  logic             calibrated_r, calibrated_nxt;
  logic [LEN_W-1:0] samples_r, samples_nxt;
  logic             motor_r, motor_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic [LEN_W-1:0] samples_inc;
  logic [LEN_W-1:0] len;
  logic             out_free;

  assign accept      = in_valid && (state_r == ST_IDLE);
  assign samples_inc = samples_r + LEN_W'(1);
  assign len         = clamp_len(average_length);
  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_TENSION: begin
              if (!calibrated_r && (samples_inc >= len)) begin
                state_nxt = ST_DIV_LOAD;
              end
            end
            OP_TICK: begin
              if (captured_r && calibrated_r) begin
                state_nxt = ST_PREP;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: state_nxt = ST_IDLE;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = motor_r ? ST_OUT : ST_PREP;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands and flag updates
  always_comb begin
    cmd            = '0;
    captured_nxt   = captured_r;
    calibrated_nxt = calibrated_r;
    samples_nxt    = samples_r;
    motor_nxt      = motor_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    cmd.motor = motor_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(operation))
            OP_POSITION: begin
              cmd.load_pos = 1'b1;
              if (!captured_r) begin
                cmd.capture_ref = 1'b1;
                captured_nxt    = 1'b1;
              end
            end
            OP_TENSION: begin
              cmd.load_ten = 1'b1;
              if (!calibrated_r) begin
                cmd.accum   = 1'b1;
                samples_nxt = samples_inc;
              end
            end
            OP_TICK: begin
              motor_nxt = 1'b0;
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_DIV_LOAD: cmd.div_load = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_BASE: begin
        cmd.base_write = 1'b1;
        calibrated_nxt = 1'b1;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_MUL:  cmd.mul  = 1'b1;
      ST_ACC: begin
        cmd.acc   = 1'b1;
        motor_nxt = !motor_r;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      captured_r   <= 1'b0;
      calibrated_r <= 1'b0;
      samples_r    <= '0;
      motor_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      captured_r   <= captured_nxt;
      calibrated_r <= calibrated_nxt;
      samples_r    <= samples_nxt;
      motor_r      <= motor_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/tzpc_datapath.sv @@
module tzpc_datapath
  import tzpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  input  cmd_t      cmd,
  output logic      div_done,
  output out_item_t out_item
);

  logic signed [31:0]       ref_r [2];
  logic signed [31:0]       pos_r [2];
  logic signed [15:0]       ten_r [2];
  logic signed [SUM_W-1:0]  sum_r [2];
  logic signed [BASE_W-1:0] base_r [2];

  logic [SUM_W-1:0]     quo_r [2];
  logic [REM_W-1:0]     rem_r [2];
  logic                 neg_r [2];
  logic [DIV_CNT_W-1:0] cnt_r;

  logic [1:0]                zone_r;
  logic signed [MUL_A_W-1:0] mul_a_r;
  logic signed [MUL_B_W-1:0] mul_b_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [31:0]        res_cmd_r [2];
  logic [1:0]                res_zone_r [2];
  out_item_t                 out_r;

  logic signed [15:0]        pick [2];
  logic [LEN_W-1:0]          len;
  logic [REM_W:0]            trial [2];
  logic [SUM_W-1:0]          qmag [2];
  logic signed [SUM_W-1:0]   qsig [2];

  logic signed [DEV_W-1:0]   ten_x, base_x, band_x, dev;
  logic signed [MUL_B_W-1:0] theta;
  logic [1:0]                zone_sel;
  logic signed [MUL_A_W-1:0] mul_a_sel;
  logic signed [MUL_B_W-1:0] mul_b_sel;
  logic signed [PROD_W-1:0]  shr, tq, adj;
  logic signed [ACC_W-1:0]   sum_v;

  assign pick[0]  = pick_sensor(in_item, cfg.sensor_select_a);
  assign pick[1]  = pick_sensor(in_item, cfg.sensor_select_b);
  assign len      = clamp_len(cfg.average_length);
  assign div_done = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_r[i], quo_r[i][SUM_W-1]};
      qmag[i]  = neg_r[i] ? (~quo_r[i] + SUM_W'(1)) : quo_r[i];
      qsig[i]  = qmag[i];
    end
  end

  // zone decision and multiplier operands for the selected motor
  always_comb begin
    ten_x  = DEV_W'(ten_r[cmd.motor]);
    base_x = DEV_W'(base_r[cmd.motor]);
    band_x = DEV_W'(cfg.tension_band);
    dev    = ten_x - base_x;
    theta  = MUL_B_W'(pos_r[cmd.motor]) - MUL_B_W'(ref_r[cmd.motor]);
    if (ten_x < base_x) begin
      zone_sel  = ZONE_PULL;
      mul_a_sel = MUL_A_W'(cfg.pull_gain);
      mul_b_sel = MUL_B_W'(dev);
    end else if (dev > band_x) begin
      zone_sel  = ZONE_RELEASE;
      mul_a_sel = MUL_A_W'(cfg.pull_gain);
      mul_b_sel = MUL_B_W'(dev - band_x);
    end else begin
      zone_sel  = ZONE_HOLD;
      mul_a_sel = MUL_A_W'(cfg.hold_gain_q8);
      mul_b_sel = theta;
    end
  end

  // hold term truncates toward zero
  always_comb begin
    shr   = prod_r >>> FRAC_W;
    tq    = shr + PROD_W'(prod_r[PROD_W-1] && (|prod_r[FRAC_W-1:0]));
    adj   = (zone_r == ZONE_HOLD) ? -tq : prod_r;
    sum_v = ACC_W'(pos_r[cmd.motor]) + ACC_W'(adj);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r[0] <= '0;
      sum_r[1] <= '0;
    end else if (cmd.accum) begin
      for (int i = 0; i < 2; i++) begin
        sum_r[i] <= sum_r[i] + SUM_W'(pick[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (cmd.load_ten) begin
        ten_r[i] <= pick[i];
      end
      if (cmd.div_load) begin
        neg_r[i] <= sum_r[i][SUM_W-1];
        quo_r[i] <= sum_r[i][SUM_W-1] ? (~sum_r[i] + SUM_W'(1)) : sum_r[i];
        rem_r[i] <= '0;
      end else if (cmd.div_step) begin
        if (trial[i] >= (REM_W + 1)'(len)) begin
          rem_r[i] <= REM_W'(trial[i] - (REM_W + 1)'(len));
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= trial[i][REM_W-1:0];
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b0};
        end
      end
      if (cmd.base_write) begin
        base_r[i] <= BASE_W'(qsig[i]) + BASE_W'(cfg.tension_offset);
      end
    end
    if (cmd.load_pos) begin
      pos_r[0] <= in_item.position_1;
      pos_r[1] <= in_item.position_2;
    end
    if (cmd.capture_ref) begin
      ref_r[0] <= in_item.position_1;
      ref_r[1] <= in_item.position_2;
    end
    if (cmd.prep) begin
      zone_r  <= zone_sel;
      mul_a_r <= mul_a_sel;
      mul_b_r <= mul_b_sel;
    end
    if (cmd.mul) begin
      prod_r <= mul_a_r * mul_b_r;
    end
    if (cmd.acc) begin
      res_cmd_r[cmd.motor]  <= sat32(sum_v);
      res_zone_r[cmd.motor] <= zone_r;
    end
    if (cmd.load_out) begin
      out_r.command_1 <= res_cmd_r[0];
      out_r.command_2 <= res_cmd_r[1];
      out_r.zone_1    <= res_zone_r[0];
      out_r.zone_2    <= res_zone_r[1];
    end
  end

  assign out_item = out_r;

endmodule

@@ hdl/tension_zone_position_controller.sv @@
// Position and tension samples return straight to idle; the tension sample that
// completes calibration first runs the two-lane restoring divider (22 steps).
// A control tick runs, per motor, a zone/operand step, a multiply step and an
// accumulate step over a shared 17x33 multiplier, then the output load.
// The result register frees the input while a transfer waits on out_stall.
// Synchronous active-low reset restores register defaults, clears flags, sums, counters.
module tension_zone_position_controller
  import tzpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  cmd_t cmd;
  logic div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tension_offset  <= RST_TENSION_OFFSET;
      cfg_r.pull_gain       <= RST_PULL_GAIN;
      cfg_r.hold_gain_q8    <= RST_HOLD_GAIN_Q8;
      cfg_r.sensor_select_a <= RST_SENSOR_SELECT_A;
      cfg_r.sensor_select_b <= RST_SENSOR_SELECT_B;
      cfg_r.tension_band    <= RST_TENSION_BAND;
      cfg_r.average_length  <= RST_AVERAGE_LENGTH;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_TENSION_OFFSET:  cfg_r.tension_offset  <= cfg_data[11:0];
        REG_PULL_GAIN:       cfg_r.pull_gain       <= cfg_data[7:0];
        REG_HOLD_GAIN_Q8:    cfg_r.hold_gain_q8    <= cfg_data[15:0];
        REG_SENSOR_SELECT_A: cfg_r.sensor_select_a <= cfg_data[1:0];
        REG_SENSOR_SELECT_B: cfg_r.sensor_select_b <= cfg_data[1:0];
        REG_TENSION_BAND:    cfg_r.tension_band    <= cfg_data[11:0];
        REG_AVERAGE_LENGTH:  cfg_r.average_length  <= cfg_data[6:0];
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  tzpc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .operation      (in_item.operation),
    .out_stall      (out_stall),
    .average_length (cfg_r.average_length),
    .div_done       (div_done),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .cmd            (cmd)
  );

  tzpc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .div_done (div_done),
    .out_item (out_item)
  );

endmodule
